// ----- rtl/core/hlg_pkg.sv -----
// Shared types and constants of the multiclass hinge loss gradient block.
`default_nettype none

package hlg_pkg;

   // Parameter defaults
   localparam int MAX_CLASSES_DEF = 32;
   localparam int SCORE_WIDTH_DEF = 16;

   // Field widths
   localparam int SCORE_W     = 16;
   localparam int CLASS_W     = 5;
   localparam int MARGIN_W    = 15;
   localparam int BATCH_W     = 11;
   localparam int GRAD_W      = 16;
   localparam int LOSS_W      = 31;
   localparam int ACC_W       = 32;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 1;

   // Row length field of a descriptor covers up to 127 classes.
   localparam int ROW_LEN_W = 7;

   // One queue entry for each buffer bank.
   localparam int QUEUE_DEPTH = 2;

   // Divider geometry: a long run walks all dividend bits, a short run the low half.
   localparam int DIV_W       = 32;
   localparam int DIV_SHORT_W = 16;

   // One in Q8.8.
   localparam int Q8_SHIFT = 8;
   localparam logic [DIV_SHORT_W-1:0] Q8_ONE = DIV_SHORT_W'(256);

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATCH_SIZE = 1'b1;
   localparam logic [MARGIN_W-1:0]    MARGIN_RESET   = 15'd256;
   localparam logic [BATCH_W-1:0]     BATCH_RESET    = 11'd1;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [CLASS_W-1:0]        true_class;
      logic                      row_end;
      logic                      batch_end;
   } req_word_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gradient;
      logic [CLASS_W-1:0]       class_index;
      logic [LOSS_W-1:0]        batch_loss;
      logic                     loss_valid;
      logic                     row_error;
      logic                     last;
   } rsp_word_type;

   // A closed row as handed from the front to the back.
   typedef struct packed {
      logic [ROW_LEN_W-1:0] len;
      logic [CLASS_W-1:0]   label;
      logic                 err;
      logic                 batch_end;
   } row_desc_type;

   typedef struct packed {
      logic               start;
      logic               short_op;
      logic [DIV_W-1:0]   dividend;
      logic [BATCH_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_res_type;

endpackage

`default_nettype wire

// ----- rtl/core/hlg_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module hlg_ram #(
   parameter int WIDTH = hlg_pkg::SCORE_WIDTH_DEF,
   parameter int DEPTH = 2 * hlg_pkg::MAX_CLASSES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hlg_front.sv -----
// Front end: accepts score words, fills the row buffer and closes rows into descriptors.
`default_nettype none

module hlg_front #(
   parameter int MAX_CLASSES = hlg_pkg::MAX_CLASSES_DEF,
   parameter int SCORE_WIDTH = hlg_pkg::SCORE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hlg_pkg::req_word_type              req_word,
   input  logic                               q_full,
   output logic                               q_push,
   output hlg_pkg::row_desc_type              q_desc,
   output logic                               buf_wr_en,
   output logic [$clog2(2*MAX_CLASSES)-1:0]   buf_wr_addr,
   output logic [SCORE_WIDTH-1:0]             buf_wr_data
);

   import hlg_pkg::*;

   localparam int IDX_W = $clog2(MAX_CLASSES);
   localparam int LEN_W = $clog2(MAX_CLASSES + 1);
   localparam int CMP_W = (LEN_W > CLASS_W) ? LEN_W : CLASS_W;

   logic [LEN_W-1:0]     row_len_ff, row_len_in;
   logic                 ovf_ff, ovf_in;
   logic                 bank_ff, bank_in;
   logic                 accept;
   logic                 has_room;
   logic [LEN_W-1:0]     n_close;
   logic [2*SCORE_W-1:0] score_wide;

   // A new word is taken whenever the queue can hold one more closed row,
   // which also means the bank being filled is not in use by the back end.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign has_room  = row_len_ff < LEN_W'(MAX_CLASSES);
   assign n_close   = has_room ? (row_len_ff + LEN_W'(1)) : row_len_ff;

   // The score field is taken at the buffer width.
   assign score_wide  = {SCORE_W'(0), req_word.score};
   assign buf_wr_en   = accept && has_room;
   assign buf_wr_addr = {bank_ff, row_len_ff[IDX_W-1:0]};
   assign buf_wr_data = score_wide[SCORE_WIDTH-1:0];

   // Row close: describe the row for the back end.
   assign q_push           = accept && req_word.row_end;
   assign q_desc.len       = ROW_LEN_W'(n_close);
   assign q_desc.label     = req_word.true_class;
   assign q_desc.err       = ovf_ff || !has_room ||
                             (CMP_W'(req_word.true_class) >= CMP_W'(n_close));
   assign q_desc.batch_end = req_word.batch_end;

   // Row length, overflow and bank bookkeeping.
   always_comb begin
      row_len_in = row_len_ff;
      ovf_in     = ovf_ff;
      bank_in    = bank_ff;
      if (accept) begin
         if (req_word.row_end) begin
            row_len_in = '0;
            ovf_in     = 1'b0;
            bank_in    = !bank_ff;
         end else if (has_room) begin
            row_len_in = row_len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff <= '0;
         ovf_ff     <= 1'b0;
         bank_ff    <= 1'b0;
      end else begin
         row_len_ff <= row_len_in;
         ovf_ff     <= ovf_in;
         bank_ff    <= bank_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/hlg_queue.sv -----
// Small descriptor queue between the front end and the back end.
`default_nettype none

module hlg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hlg_pkg::row_desc_type push_desc,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output hlg_pkg::row_desc_type head
);

   import hlg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   row_desc_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/hlg_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, short or long dividend.
`default_nettype none

module hlg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  hlg_pkg::div_cmd_type cmd,
   output hlg_pkg::div_res_type res
);

   import hlg_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [BATCH_W-1:0]   rem_ff, rem_in;
   logic [BATCH_W-1:0]   dvs_ff, dvs_in;
   logic [BATCH_W:0]     trial;
   logic [BATCH_W:0]     diff;
   logic                 fits;

   // Shift the next dividend bit into the partial remainder and try the subtract.
   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         // A short run places the low half at the top so only it is walked.
         busy_in = 1'b1;
         dvd_in  = cmd.short_op ? {cmd.dividend[DIV_SHORT_W-1:0], DIV_SHORT_W'(0)}
                                : cmd.dividend;
         cnt_in  = cmd.short_op ? CNT_W'(DIV_SHORT_W) : CNT_W'(DIV_W);
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[BATCH_W-1:0] : trial[BATCH_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hlg_back.sv -----
// Back end: scans a buffered row, runs the divisions and emits one gradient word per class.
`default_nettype none

module hlg_back #(
   parameter int MAX_CLASSES = hlg_pkg::MAX_CLASSES_DEF,
   parameter int SCORE_WIDTH = hlg_pkg::SCORE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  hlg_pkg::row_desc_type            q_head,
   output logic                             q_pop,
   output logic [$clog2(2*MAX_CLASSES)-1:0] buf_rd_addr,
   input  logic [SCORE_WIDTH-1:0]           buf_rd_data,
   input  logic [hlg_pkg::MARGIN_W-1:0]     margin,
   input  logic [hlg_pkg::BATCH_W-1:0]      batch_size,
   output hlg_pkg::div_cmd_type             div_cmd,
   input  hlg_pkg::div_res_type             div_res,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hlg_pkg::rsp_word_type            rsp_word
);

   import hlg_pkg::*;

   localparam int IDX_W  = $clog2(MAX_CLASSES);
   localparam int LEN_W  = $clog2(MAX_CLASSES + 1);
   localparam int CMP_W  = (LEN_W > CLASS_W) ? LEN_W : CLASS_W;
   localparam int TERM_W = ((SCORE_WIDTH > MARGIN_W) ? SCORE_WIDTH : MARGIN_W) + 2;
   localparam int SUM_W  = ((ACC_W > TERM_W - 1) ? ACC_W : TERM_W - 1) + 1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_T_DATA   = 8'b0000_0010,
      ST_SCAN     = 8'b0000_0100,
      ST_DRAIN    = 8'b0000_1000,
      ST_DIV_UNIT = 8'b0001_0000,
      ST_DIV_TRUE = 8'b0010_0000,
      ST_DIV_LOSS = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic                      bank_ff, bank_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [SCORE_WIDTH-1:0] t_ff, t_in;
   logic [TERM_W-2:0]         term_ff, term_in;
   logic                      term_vld_ff, term_vld_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [LEN_W-1:0]          positives_ff, positives_in;
   logic [MAX_CLASSES-1:0]    pos_ff, pos_in;
   logic [GRAD_W-1:0]         q_unit_ff, q_unit_in;
   logic [GRAD_W-1:0]         q_true_ff, q_true_in;
   logic [LOSS_W-1:0]         loss_ff, loss_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   logic [IDX_W-1:0]          label_idx;
   logic [IDX_W-1:0]          last_idx;
   logic                      idx_last;
   logic signed [TERM_W-1:0]  term;
   logic                      is_pos;
   logic [SUM_W-1:0]          acc_sum;
   logic signed [GRAD_W-1:0]  grad;
   logic                      slot_free;

   // Row facts from the head descriptor, which stays in the queue until the row is done.
   assign label_idx = IDX_W'(CMP_W'(q_head.label));
   assign last_idx  = IDX_W'(q_head.len - ROW_LEN_W'(1));
   assign idx_last  = idx_ff == last_idx;

   // Hinge term of the class whose score arrives from the buffer this cycle.
   assign term   = TERM_W'(signed'({1'b0, margin})) - TERM_W'(t_ff)
                 + TERM_W'(signed'(buf_rd_data));
   assign is_pos = !term[TERM_W-1] && (term != '0) && (idx_ff != label_idx);

   // Saturating loss accumulation, one stage after the term.
   assign acc_sum = SUM_W'(acc_ff) + SUM_W'(term_ff);

   // Gradient of the class being emitted.
   always_comb begin
      if (q_head.err) begin
         grad = '0;
      end else if (idx_ff == label_idx) begin
         grad = -signed'(q_true_ff);
      end else if (pos_ff[idx_ff]) begin
         grad = signed'(q_unit_ff);
      end else begin
         grad = '0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      term_in      = term_ff;
      term_vld_in  = 1'b0;
      acc_in       = acc_ff;
      positives_in = positives_ff;
      pos_in       = pos_ff;
      q_unit_in    = q_unit_ff;
      q_true_in    = q_true_ff;
      loss_in      = loss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      q_pop        = 1'b0;
      buf_rd_addr  = {bank_ff, idx_ff};
      div_cmd          = '0;
      div_cmd.divisor  = batch_size;

      // Fold the previous positive term into the loss and the positive count.
      if (term_vld_ff) begin
         acc_in       = (acc_sum[SUM_W-1:ACC_W] != '0) ? '1 : acc_sum[ACC_W-1:0];
         positives_in = positives_ff + LEN_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Read the true score ahead; a faulty row skips the scan.
            buf_rd_addr = {bank_ff, label_idx};
            if (!q_empty) begin
               positives_in = '0;
               pos_in       = '0;
               state_in     = q_head.err ? ST_DRAIN : ST_T_DATA;
            end
         end
         ST_T_DATA: begin
            t_in        = signed'(buf_rd_data);
            buf_rd_addr = {bank_ff, IDX_W'(0)};
            idx_in      = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            buf_rd_addr    = {bank_ff, idx_ff + IDX_W'(1)};
            term_vld_in    = is_pos;
            term_in        = is_pos ? term[TERM_W-2:0] : '0;
            pos_in[idx_ff] = is_pos;
            if (idx_last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // Last term lands in the accumulator; start one over batch size.
            div_cmd.start    = 1'b1;
            div_cmd.short_op = 1'b1;
            div_cmd.dividend = DIV_W'(Q8_ONE);
            idx_in           = '0;
            state_in         = ST_DIV_UNIT;
         end
         ST_DIV_UNIT: begin
            if (div_res.done) begin
               q_unit_in        = GRAD_W'(div_res.quotient);
               div_cmd.start    = 1'b1;
               div_cmd.short_op = 1'b1;
               div_cmd.dividend = DIV_W'(positives_ff) << Q8_SHIFT;
               state_in         = ST_DIV_TRUE;
            end
         end
         ST_DIV_TRUE: begin
            if (div_res.done) begin
               q_true_in = GRAD_W'(div_res.quotient);
               if (q_head.batch_end) begin
                  div_cmd.start    = 1'b1;
                  div_cmd.short_op = 1'b0;
                  div_cmd.dividend = acc_ff;
                  state_in         = ST_DIV_LOSS;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV_LOSS: begin
            if (div_res.done) begin
               loss_in  = div_res.quotient[DIV_W-1] ? '1 : div_res.quotient[LOSS_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.gradient    = grad;
               rsp_word_in.class_index = CLASS_W'(CMP_W'(idx_ff));
               rsp_word_in.loss_valid  = idx_last && q_head.batch_end;
               rsp_word_in.batch_loss  = (idx_last && q_head.batch_end) ? loss_ff : '0;
               rsp_word_in.row_error   = q_head.err;
               rsp_word_in.last        = idx_last;
               if (idx_last) begin
                  q_pop    = 1'b1;
                  bank_in  = !bank_ff;
                  state_in = ST_IDLE;
                  if (q_head.batch_end) begin
                     acc_in = '0;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         idx_ff       <= '0;
         term_vld_ff  <= 1'b0;
         acc_ff       <= '0;
         positives_ff <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         idx_ff       <= idx_in;
         term_vld_ff  <= term_vld_in;
         acc_ff       <= acc_in;
         positives_ff <= positives_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      term_ff     <= term_in;
      q_unit_ff   <= q_unit_in;
      q_true_ff   <= q_true_in;
      loss_ff     <= loss_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/core/multiclass_hinge_loss_gradient.sv -----
// Top level of the multiclass hinge loss gradient block.
//
// Channel   Ports                               Dir  Transfer
// request   req_valid, req_ready, req_word      in   valid/ready, one score per word
// response  rsp_valid, rsp_ready, rsp_word      out  valid/ready, one class per word
// config    csr_wr_en, csr_index, csr_wdata     in   write strobe, no wait state
//
// The front end takes one score per cycle into a two-bank row buffer; it stalls only
// when two closed rows are held in the queue, the one in the back end included.
// A row of n classes passes through the back end in order: the true score fetch, a scan
// over the buffer read port, a drain step, two 16-step divisions in the shared radix-2
// divider, and an emit step for each class; a batch-closing row adds a 32-step division.
// A faulty row skips the fetch and the scan.
// Reset is synchronous; the row buffer needs no clearing.
// A low rsp_ready holds the back end in its emit step without losing a word.
`default_nettype none

module multiclass_hinge_loss_gradient #(
   parameter int MAX_CLASSES = hlg_pkg::MAX_CLASSES_DEF,
   parameter int SCORE_WIDTH = hlg_pkg::SCORE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hlg_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hlg_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_wr_en,
   input  logic [hlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hlg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import hlg_pkg::*;

   // Each bank spans a power of two so the bank bit can lead the address.
   localparam int BUF_DEPTH = 2 * (2 ** $clog2(MAX_CLASSES));
   localparam int BUF_AW    = $clog2(BUF_DEPTH);

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [BATCH_W-1:0]  batch_ff, batch_in;
   logic [BATCH_W-1:0]  batch_eff;

   logic                q_full;
   logic                q_empty;
   logic                q_push;
   logic                q_pop;
   row_desc_type        q_desc;
   row_desc_type        q_head;

   logic                buf_wr_en;
   logic [BUF_AW-1:0]   buf_wr_addr;
   logic [SCORE_WIDTH-1:0] buf_wr_data;
   logic [BUF_AW-1:0]   buf_rd_addr;
   logic [SCORE_WIDTH-1:0] buf_rd_data;

   div_cmd_type         div_cmd;
   div_res_type         div_res;

   // Configuration registers.
   always_comb begin
      margin_in = margin_ff;
      batch_in  = batch_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MARGIN:     margin_in = csr_wdata[MARGIN_W-1:0];
            CSR_BATCH_SIZE: batch_in  = csr_wdata[BATCH_W-1:0];
            default: begin
               margin_in = margin_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         batch_ff  <= BATCH_RESET;
      end else begin
         margin_ff <= margin_in;
         batch_ff  <= batch_in;
      end
   end

   // A batch size of zero divides as one.
   assign batch_eff = (batch_ff == '0) ? BATCH_W'(1) : batch_ff;

   hlg_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (q_desc),
      .buf_wr_en   (buf_wr_en),
      .buf_wr_addr (buf_wr_addr),
      .buf_wr_data (buf_wr_data)
   );

   hlg_ram #(
      .WIDTH (SCORE_WIDTH),
      .DEPTH (BUF_DEPTH)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   hlg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   hlg_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   hlg_back #(
      .MAX_CLASSES (MAX_CLASSES),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data),
      .margin      (margin_ff),
      .batch_size  (batch_eff),
      .div_cmd     (div_cmd),
      .div_res     (div_res),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

// ----- rtl/core/hlg_checker.sv -----
// Port-level assertions for the multiclass hinge loss gradient block, with its bind.
`default_nettype none

module hlg_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input hlg_pkg::rsp_word_type rsp_word
);

   // No response word is offered right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The batch loss only comes with the closing word of a row.
   a_loss_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.loss_valid |-> rsp_word.last)
      else $error("loss word is not the last word of its row");

   // Without a finished loss the loss field reads zero.
   a_loss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.loss_valid |-> rsp_word.batch_loss == '0)
      else $error("batch loss nonzero without loss_valid");

   // A faulty row carries only zero gradients.
   a_error_zero_grad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.row_error |-> rsp_word.gradient == '0)
      else $error("nonzero gradient on a faulty row");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

endmodule

bind multiclass_hinge_loss_gradient hlg_checker u_hlg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the multiclass hinge loss gradient block.
`timescale 1ns / 100ps

module testbench;
   import hlg_pkg::*;

   localparam int ROW_CAP       = MAX_CLASSES_DEF;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CONFIG_STRIDE = 90;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MARGIN;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Traffic shaping: no random idling while steady is set; rsp_hold forces a long stall.
   logic steady   = 1'b0;
   logic rsp_hold = 1'b0;
   event rsp_hold_go;

   // Shadow of the block: row buffer, loss accumulator and registers.
   logic signed [SCORE_W-1:0] row_scores [ROW_CAP];
   int unsigned               row_fill   = 0;
   bit                        row_spilled = 1'b0;
   longint unsigned           loss_sum   = 0;
   logic [MARGIN_W-1:0]       margin_reg = MARGIN_RESET;
   logic [BATCH_W-1:0]        batch_reg  = BATCH_RESET;

   // Gradient words still owed by the block, oldest first.
   rsp_word_type pending_grads [$];

   int mismatch_count  = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int rows_closed     = 0;
   int faulty_rows     = 0;
   int loss_reports    = 0;

   multiclass_hinge_loss_gradient dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Buffer one score and, when the row closes, queue the gradient words it yields.
   task automatic compute_gradients(input req_word_type w);
      int unsigned     n;
      int unsigned     divisor;
      int unsigned     hits;
      longint          true_score;
      longint          term;
      longint          grad;
      longint unsigned row_loss;
      longint unsigned avg;
      bit              bad;
      bit              hit [ROW_CAP];
      rsp_word_type    r;

      hits     = 0;
      row_loss = 0;
      if (row_fill < ROW_CAP) begin
         row_scores[row_fill] = w.score;
         row_fill++;
      end else begin
         row_spilled = 1'b1;
      end
      if (!w.row_end) return;

      n       = row_fill;
      bad     = row_spilled || (w.true_class >= n);
      divisor = (batch_reg == '0) ? 1 : batch_reg;
      rows_closed++;
      if (bad) faulty_rows++;

      // Hinge terms against the true score; only clean rows add to the loss.
      if (!bad) begin
         true_score = row_scores[w.true_class];
         for (int j = 0; j < n; j++) begin
            term   = longint'(margin_reg) - true_score + longint'(row_scores[j]);
            hit[j] = (j != w.true_class) && (term > 0);
            if (hit[j]) begin
               hits++;
               row_loss += longint'(term);
            end
         end
         loss_sum += row_loss;
         if (loss_sum > 64'hFFFF_FFFF) loss_sum = 64'hFFFF_FFFF;
      end

      // One word per buffered class; the last one of a batch carries the loss.
      for (int j = 0; j < n; j++) begin
         grad = 0;
         if (!bad) begin
            if (j == w.true_class) grad = -longint'((hits * int'(Q8_ONE)) / divisor);
            else if (hit[j]) grad = longint'(int'(Q8_ONE) / divisor);
         end
         r             = '0;
         r.gradient    = GRAD_W'(grad);
         r.class_index = CLASS_W'(j);
         r.row_error   = bad;
         r.last        = (j == n - 1);
         if (r.last && w.batch_end) begin
            avg = loss_sum / divisor;
            if (avg > 64'h7FFF_FFFF) avg = 64'h7FFF_FFFF;
            r.batch_loss = LOSS_W'(avg);
            r.loss_valid = 1'b1;
            loss_sum     = 0;
         end
         pending_grads.push_back(r);
      end
      row_fill    = 0;
      row_spilled = 1'b0;
   endtask

   // Offer one score word and hold it until the block takes it.
   task automatic send_score(input logic signed [SCORE_W-1:0] score, input int true_class,
                             input bit row_end, input bit batch_end);
      req_word_type w;

      w.score      = score;
      w.true_class = CLASS_W'(true_class);
      w.row_end    = row_end;
      w.batch_end  = batch_end;
      while (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      compute_gradients(w);
   endtask

   // A row with random scores; filler words carry random labels and batch flags.
   task automatic send_random_row(input int len, input int label, input bit closes_batch);
      logic signed [SCORE_W-1:0] score;

      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0:       score = 16'sh7FFF;
            1:       score = 16'sh8000;
            2, 3, 4: score = SCORE_W'($urandom);
            default: score = SCORE_W'(int'($urandom_range(1023)) - 512);
         endcase
         if (i == len - 1) send_score(score, label, 1'b1, closes_batch);
         else send_score(score, $urandom_range(31), 1'b0, $urandom_range(1));
      end
   endtask

   // Wait until every owed word has arrived and the block has gone quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_grads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MARGIN) margin_reg = MARGIN_W'(value);
      else batch_reg = BATCH_W'(value);
   endtask

   // Registers change only with the block idle.
   task automatic reconfigure(input int margin, input int batch);
      drain_results();
      write_csr(CSR_MARGIN, margin);
      write_csr(CSR_BATCH_SIZE, batch);
   endtask

   // Reset settings: extreme scores, a stray batch flag on a filler word, large terms.
   task automatic test_reset_values();
      send_score(16'sh7FFF, 9, 1'b0, 1'b1);
      send_score(16'sh8000, 0, 1'b0, 1'b0);
      send_score(16'sh0000, 31, 1'b0, 1'b0);
      send_score(16'sh0100, 1, 1'b1, 1'b1);
   endtask

   // A clean row leaves loss pending; a row whose label lies past its end reports it.
   task automatic test_faulty_rows();
      send_score(16'sh0040, 4, 1'b0, 1'b0);
      send_score(-16'sh0040, 0, 1'b1, 1'b0);
      send_score(16'sh1000, 0, 1'b0, 1'b0);
      send_score(16'sh2000, 31, 1'b1, 1'b1);
   endtask

   // Zero margin gives no positive terms; the largest margin gives the largest ones.
   task automatic test_margin_limits();
      reconfigure(0, 1);
      send_score(16'sh0005, 0, 1'b0, 1'b0);
      send_score(16'sh0005, 0, 1'b0, 1'b0);
      send_score(16'sh0005, 2, 1'b1, 1'b0);
      reconfigure(32767, 1);
      send_score(16'sh7FFF, 0, 1'b0, 1'b0);
      send_score(16'sh8000, 0, 1'b0, 1'b0);
      send_score(16'sh7FFF, 0, 1'b1, 1'b1);
   endtask

   // A batch size of zero acts as one; large sizes truncate gradients to zero.
   task automatic test_batch_divisor();
      reconfigure(256, 0);
      send_score(16'sh0010, 3, 1'b0, 1'b0);
      send_score(16'sh0000, 1, 1'b1, 1'b1);
      reconfigure(32767, 1024);
      send_score(16'sh0000, 0, 1'b0, 1'b0);
      send_score(16'sh0000, 0, 1'b0, 1'b0);
      send_score(16'sh0000, 0, 1'b1, 1'b1);
      reconfigure(32767, 3);
      send_score(16'sh0000, 0, 1'b0, 1'b0);
      send_score(16'sh0000, 0, 1'b0, 1'b0);
      send_score(16'sh0000, 0, 1'b1, 1'b1);
   endtask

   // Stall the receiver for a long stretch while rows keep coming, filling both banks.
   task automatic test_backpressure();
      reconfigure(256, 4);
      -> rsp_hold_go;
      for (int r = 0; r < 6; r++) send_random_row(8, $urandom_range(7), r == 5);
   endtask

   // Random rows over several register settings, mostly well formed.
   task automatic test_random_rows();
      int  start_count;
      int  next_config;
      int  len;
      int  label;
      int  span;
      int  done_items;
      int  pick;

      start_count = items_sent;
      next_config = CONFIG_STRIDE;
      reconfigure($urandom_range(1023), $urandom_range(1, 8));

      // An overlong row and a full row whose label is the highest class.
      send_random_row(ROW_CAP + 2, 3, 1'b0);
      send_random_row(ROW_CAP, ROW_CAP - 1, 1'b1);

      done_items = items_sent - start_count;
      while (done_items < RANDOM_ITEMS) begin
         if (done_items >= next_config) begin
            next_config += CONFIG_STRIDE;
            case ($urandom_range(3))
               0:       reconfigure(0, $urandom_range(1, 6));
               1:       reconfigure(32767, 1024);
               2:       reconfigure($urandom_range(32767), $urandom_range(1, 1024));
               default: reconfigure($urandom_range(1023), 1);
            endcase
         end
         // The middle stretch runs with no idling on either side.
         steady <= (done_items > CONFIG_STRIDE) && (done_items < 2 * CONFIG_STRIDE);

         pick = $urandom_range(99);
         if (pick < 8) len = $urandom_range(ROW_CAP + 1, ROW_CAP + 4);
         else if (pick < 20) len = $urandom_range(17, ROW_CAP);
         else len = $urandom_range(1, 10);
         span = (len > ROW_CAP) ? ROW_CAP : len;
         if ($urandom_range(99) < 85) label = $urandom_range(span - 1);
         else label = $urandom_range(31);
         send_random_row(len, label, $urandom_range(99) < 30);
         done_items = items_sent - start_count;
      end
      steady <= 1'b0;
   endtask

   // Result side readiness: random idling, steady stretches and the long hold.
   always @(posedge clock) begin
      if (reset || rsp_hold) rsp_ready <= 1'b0;
      else if (!steady && $urandom_range(99) < 9) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   // The long hold is timed here so the sender keeps running meanwhile.
   always begin
      @(rsp_hold_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare every accepted result word with the oldest owed word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grads.size() == 0) begin
            $error("result word with none expected: %h", rsp_word);
            mismatch_count++;
         end else begin
            want = pending_grads.pop_front();
            check_field("gradient", $signed(want.gradient), $signed(rsp_word.gradient));
            check_field("class_index", want.class_index, rsp_word.class_index);
            check_field("batch_loss", want.batch_loss, rsp_word.batch_loss);
            check_field("loss_valid", want.loss_valid, rsp_word.loss_valid);
            check_field("row_error", want.row_error, rsp_word.row_error);
            check_field("last", want.last, rsp_word.last);
            results_checked++;
            if (want.loss_valid) loss_reports++;
         end
      end
   end

   // Cycle limit for a hung run.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_faulty_rows();
      test_margin_limits();
      test_batch_divisor();
      test_backpressure();
      test_random_rows();
      drain_results();

      $display("summary: %0d score words in %0d rows (%0d faulty), %0d result words checked",
               items_sent, rows_closed, faulty_rows, results_checked);
      $display("summary: %0d batch losses reported, margin and batch size taken to both limits",
               loss_reports);
      if (mismatch_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule
